/* rtl/pitp_pkg.sv */
// Package for the prefixed integer text parser.
// Payload widths, payload types and character codes; no dependencies.
package pitp_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned ValueW = 32;

  typedef logic [CharW-1:0]         char_t;
  typedef logic signed [ValueW-1:0] value_t;

  // Character codes the parser reacts to
  localparam char_t CharNul   = 8'h00;
  localparam char_t CharMinus = 8'h2D;  // '-'
  localparam char_t Char0     = 8'h30;  // '0'
  localparam char_t Char9     = 8'h39;  // '9'
  localparam char_t CharUpA   = 8'h41;  // 'A'
  localparam char_t CharUpF   = 8'h46;  // 'F'
  localparam char_t CharLoA   = 8'h61;  // 'a'
  localparam char_t CharLoB   = 8'h62;  // 'b'
  localparam char_t CharLoF   = 8'h66;  // 'f'
  localparam char_t CharLoX   = 8'h78;  // 'x'

endpackage

/* rtl/pitp_char_if.sv */
// Valid/ready channel that carries one character per transfer.
// Depends on pitp_pkg.
interface pitp_char_if;
  import pitp_pkg::*;

  logic  valid;
  logic  ready;
  char_t char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

/* rtl/pitp_result_if.sv */
// Valid/ready channel that carries one parse result per transfer.
// Depends on pitp_pkg.
interface pitp_result_if;
  import pitp_pkg::*;

  logic   valid;
  logic   ready;
  value_t value;
  logic   invalid;

  modport source (output valid, output value, output invalid, input ready);
  modport sink   (input valid, input value, input invalid, output ready);
endinterface

/* rtl/prefixed_integer_text_parser.sv */
// Prefixed integer text parser, top level.
// Depends on pitp_pkg, pitp_char_if and pitp_result_if.
//
// Usage:
//   in_i  : one character per transfer. A zero character ends the string.
//   out_o : one result per terminator: signed 32-bit value and invalid flag.
//   Prefix "0b" selects binary, "0x" hex, a leading '0' octal, else decimal.
//   One '-' is allowed right after the prefix and negates the result.
//   Any other character makes the result 0 with invalid set.
// Timing:
//   One character is taken every cycle while in_i.ready is high. A result
//   shows on out_o in the cycle after its terminator transfer when the
//   output register is free, else once the results ahead of it are taken.
//   The rate is set by the single shift-add of the accumulator.
// Reset:
//   rst_ni clears the parse state to string start and empties the output.
// Stalls:
//   Results sit in a two-entry output buffer (output register plus skid
//   register). Characters keep flowing while a result waits; in_i.ready
//   drops only when both entries hold results not yet taken.
module prefixed_integer_text_parser (
  input logic           clk_i,
  input logic           rst_ni,
  pitp_char_if.sink     in_i,
  pitp_result_if.source out_o
);
  import pitp_pkg::*;

  typedef enum logic [2:0] {
    PhStart  = 3'd0,
    PhZero   = 3'd1,
    PhSign   = 3'd2,
    PhDigits = 3'd3,
    PhError  = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    RadixDec = 2'd0,
    RadixBin = 2'd1,
    RadixOct = 2'd2,
    RadixHex = 2'd3
  } radix_e;

  // Parse state
  phase_e              phase_q, phase_d;
  radix_e              radix_q, radix_d;
  logic [ValueW-1:0]   acc_q, acc_d;
  logic                neg_q, neg_d;
  logic                err_q, err_d;

  // Output buffer
  logic                out_valid_q, skid_valid_q;
  value_t              out_value_q, skid_value_q;
  logic                out_invalid_q, skid_invalid_q;

  logic                in_xfer, out_xfer, is_term;
  char_t               c;
  logic [4:0]          dig;
  logic                dig_hit;
  logic [4:0]          radix_val;
  logic                take, sign_ok;
  radix_e              td_mode;
  logic [ValueW-1:0]   scaled;
  value_t              res_value;

  assign c        = in_i.char_code;
  assign is_term  = (c == CharNul);
  assign in_i.ready = !skid_valid_q;
  assign in_xfer  = in_i.valid && in_i.ready;
  assign out_xfer = out_valid_q && out_o.ready;

  // Digit decode, radix independent
  always_comb begin
    dig     = 5'd0;
    dig_hit = 1'b0;
    if (c inside {[Char0:Char9]}) begin
      dig     = 5'(c - Char0);
      dig_hit = 1'b1;
    end else if (c inside {[CharUpA:CharUpF]}) begin
      dig     = 5'(c - CharUpA) + 5'd10;
      dig_hit = 1'b1;
    end else if (c inside {[CharLoA:CharLoF]}) begin
      dig     = 5'(c - CharLoA) + 5'd10;
      dig_hit = 1'b1;
    end
  end

  // Next parse state for a non-terminator character
  always_comb begin
    phase_d = phase_q;
    radix_d = radix_q;
    acc_d   = acc_q;
    neg_d   = neg_q;
    err_d   = err_q;
    take    = 1'b0;
    sign_ok = 1'b0;
    td_mode = radix_q;

    case (phase_q)
      PhStart: begin
        if (c == Char0) begin
          phase_d = PhZero;
        end else begin
          radix_d = RadixDec;
          td_mode = RadixDec;
          take    = 1'b1;
          sign_ok = 1'b1;
        end
      end
      PhZero: begin
        if (c == CharLoB) begin
          radix_d = RadixBin;
          phase_d = PhSign;
        end else if (c == CharLoX) begin
          radix_d = RadixHex;
          phase_d = PhSign;
        end else begin
          radix_d = RadixOct;
          td_mode = RadixOct;
          take    = 1'b1;
          sign_ok = 1'b1;
        end
      end
      PhSign: begin
        take    = 1'b1;
        sign_ok = 1'b1;
      end
      PhDigits: begin
        take = 1'b1;
      end
      default: begin
        // error phase and unused codes
        err_d   = 1'b1;
        phase_d = PhError;
      end
    endcase

    case (td_mode)
      RadixDec: begin
        radix_val = 5'd10;
        scaled    = (acc_q << 3) + (acc_q << 1);
      end
      RadixBin: begin
        radix_val = 5'd2;
        scaled    = acc_q << 1;
      end
      RadixOct: begin
        radix_val = 5'd8;
        scaled    = acc_q << 3;
      end
      default: begin
        radix_val = 5'd16;
        scaled    = acc_q << 4;
      end
    endcase

    if (take) begin
      if (sign_ok && c == CharMinus) begin
        neg_d   = 1'b1;
        phase_d = PhDigits;
      end else if (!dig_hit || dig >= radix_val) begin
        err_d   = 1'b1;
        phase_d = PhError;
      end else begin
        acc_d   = scaled + ValueW'(dig);
        phase_d = PhDigits;
      end
    end
  end

  // Result for a terminator: zero on error, two's complement when negative
  always_comb begin
    if (err_q) begin
      res_value = '0;
    end else if (neg_q) begin
      res_value = value_t'(-acc_q);
    end else begin
      res_value = value_t'(acc_q);
    end
  end

  // Parse state registers; a terminator returns everything to string start
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhStart;
      radix_q <= RadixDec;
      acc_q   <= '0;
      neg_q   <= 1'b0;
      err_q   <= 1'b0;
    end else if (in_xfer) begin
      if (is_term) begin
        phase_q <= PhStart;
        radix_q <= RadixDec;
        acc_q   <= '0;
        neg_q   <= 1'b0;
        err_q   <= 1'b0;
      end else begin
        phase_q <= phase_d;
        radix_q <= radix_d;
        acc_q   <= acc_d;
        neg_q   <= neg_d;
        err_q   <= err_d;
      end
    end
  end

  // Two-entry output buffer, control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_xfer) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= in_xfer && is_term;
      end else begin
        out_valid_q  <= in_xfer && is_term;
      end
    end else if (in_xfer && is_term) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Two-entry output buffer, payload
  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_xfer) begin
      if (skid_valid_q) begin
        out_value_q    <= skid_value_q;
        out_invalid_q  <= skid_invalid_q;
        skid_value_q   <= res_value;
        skid_invalid_q <= err_q;
      end else begin
        out_value_q    <= res_value;
        out_invalid_q  <= err_q;
      end
    end else if (in_xfer && is_term) begin
      skid_value_q   <= res_value;
      skid_invalid_q <= err_q;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.value   = out_value_q;
  assign out_o.invalid = out_invalid_q;

endmodule

/* rtl/pitp_checker.sv */
// Port-level checks for the prefixed integer text parser, and their bind.
// Depends on pitp_pkg and prefixed_integer_text_parser.
module pitp_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input pitp_pkg::char_t   in_char_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input pitp_pkg::value_t  out_value_i,
  input logic              out_invalid_i
);
  import pitp_pkg::*;

  logic in_xfer;
  assign in_xfer = in_valid_i && in_ready_i;

  // A result stays offered until its transfer
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped before transfer");

  // An invalid string always reports zero
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_invalid_i |-> out_value_i == '0)
    else $error("invalid result with nonzero value");

  // A terminator into an empty output shows a result next cycle
  a_term_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && in_char_i == CharNul && !out_valid_i |=> out_valid_i)
    else $error("terminator produced no result");

  // Ordinary characters into an empty output never create a result
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && in_char_i != CharNul && !out_valid_i |=> !out_valid_i)
    else $error("result without terminator");

endmodule

bind prefixed_integer_text_parser pitp_checker u_pitp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .in_char_i     (in_i.char_code),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_value_i   (out_o.value),
  .out_invalid_i (out_o.invalid)
);
